// ===== rtl/rc4_pkg.sv =====
// ============================================================================
// rc4_pkg
// Shared constants and types for the RC4 stream cipher block.
// ============================================================================
package rc4_pkg;

   localparam int BYTE_W        = 8;
   localparam int TABLE_SIZE    = 256;
   localparam int TABLE_AW      = $clog2(TABLE_SIZE);
   localparam int KEY_BYTES_MAX = 256;
   localparam int KEY_AW        = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
   localparam int KEY_CW        = $clog2(KEY_BYTES_MAX + 1);

   localparam logic [TABLE_AW-1:0] LAST_INDEX = TABLE_AW'(TABLE_SIZE - 1);
   localparam logic [KEY_CW-1:0]   KEY_LIMIT  = KEY_CW'(KEY_BYTES_MAX);

   // Values of the mode field.
   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_DATA = 1'b1;

   // Access to the permutation table memory.
   typedef struct packed {
      logic                we;
      logic [TABLE_AW-1:0] waddr;
      logic [BYTE_W-1:0]   wdata;
      logic [TABLE_AW-1:0] raddr;
   } perm_req_type;

   // Access to the key memory.
   typedef struct packed {
      logic              we;
      logic [KEY_AW-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
      logic [KEY_AW-1:0] raddr;
   } key_req_type;

   // One finished result word from the sequencer.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] out_byte;
      logic              last_out;
   } res_type;

endpackage

// ===== rtl/rc4_ram.sv =====
// ============================================================================
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/rc4_ctrl.sv =====
// ============================================================================
// rc4_ctrl
// Sequencer for the RC4 block: table init sweep, key schedule and the
// keystream generator, all working through the table memory.
// ============================================================================
module rc4_ctrl import rc4_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [BYTE_W-1:0]   req_in_byte,
   input  logic                req_last,
   input  logic                out_free,
   output perm_req_type        perm_req,
   input  logic [BYTE_W-1:0]   perm_rdata,
   output key_req_type         key_req,
   input  logic [BYTE_W-1:0]   key_rdata,
   output res_type             res
);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_D1, ST_D2, ST_D3, ST_K0, ST_K1, ST_K2, ST_K3
   } state_type;

   state_type           state_ff, state_in;
   logic [TABLE_AW-1:0] cnt_ff, cnt_in;
   logic                run_ks_ff, run_ks_in;
   logic [BYTE_W-1:0]   i_ff, i_in;
   logic [BYTE_W-1:0]   j_ff, j_in;
   logic [BYTE_W-1:0]   si_ff, si_in;
   logic [BYTE_W-1:0]   sj_ff, sj_in;
   logic [BYTE_W-1:0]   k_ff, k_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic                last_ff, last_in;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [KEY_CW-1:0]   key_count_ff, key_count_in;
   logic [KEY_CW-1:0]   key_len_ff, key_len_in;
   logic [KEY_AW-1:0]   kidx_ff, kidx_in;

   logic                accept;
   logic [BYTE_W-1:0]   si;
   logic [BYTE_W-1:0]   j1;
   logic [BYTE_W-1:0]   ks;
   logic [BYTE_W-1:0]   jn;
   logic [BYTE_W-1:0]   i_next;
   logic                key_room;

   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_D3) && out_free);
   assign accept    = req_valid && req_ready;
   assign i_next    = i_ff + BYTE_W'(1);
   assign key_room  = (key_count_ff < KEY_LIMIT);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      run_ks_in    = run_ks_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      k_in         = k_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      fwd_hit_in   = fwd_hit_ff;
      key_count_in = key_count_ff;
      key_len_in   = key_len_ff;
      kidx_in      = kidx_ff;

      perm_req       = '0;
      perm_req.raddr = k_ff;
      key_req        = '0;
      key_req.raddr  = kidx_ff;
      res            = '0;

      si = fwd_hit_ff ? si_ff : perm_rdata;
      j1 = j_ff + si;
      jn = j_ff + key_rdata + perm_rdata;

      // The read of S[k] may miss the swap writes of this same item.
      if (k_ff == j_ff) begin
         ks = si_ff;
      end else if (k_ff == i_ff) begin
         ks = sj_ff;
      end else begin
         ks = perm_rdata;
      end

      unique case (state_ff)
         ST_INIT: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = cnt_ff;
            perm_req.wdata = cnt_ff;
            cnt_in         = cnt_ff + TABLE_AW'(1);
            if (cnt_ff == LAST_INDEX) begin
               if (run_ks_ff) begin
                  state_in = ST_K0;
                  j_in     = '0;
                  kidx_in  = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
         end
         ST_D1: begin
            perm_req.raddr = j1;
            si_in          = si;
            j_in           = j1;
            state_in       = ST_D2;
         end
         ST_D2: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = i_ff;
            perm_req.wdata = perm_rdata;
            perm_req.raddr = si_ff + perm_rdata;
            sj_in          = perm_rdata;
            k_in           = si_ff + perm_rdata;
            state_in       = ST_D3;
         end
         ST_D3: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            if (out_free) begin
               res.valid    = 1'b1;
               res.out_byte = ks ^ data_ff;
               res.last_out = last_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_K0: begin
            perm_req.raddr = cnt_ff;
            state_in       = ST_K1;
         end
         ST_K1: begin
            perm_req.raddr = jn;
            si_in          = perm_rdata;
            j_in           = jn;
            state_in       = ST_K2;
         end
         ST_K2: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = cnt_ff;
            perm_req.wdata = perm_rdata;
            state_in       = ST_K3;
         end
         ST_K3: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            cnt_in         = cnt_ff + TABLE_AW'(1);
            if (KEY_CW'(kidx_ff) + KEY_CW'(1) == key_len_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + KEY_AW'(1);
            end
            if (cnt_ff == LAST_INDEX) begin
               i_in      = '0;
               j_in      = '0;
               run_ks_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_K0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new word is taken in idle or as the previous data word leaves.
      if (accept) begin
         data_in = req_in_byte;
         last_in = req_last;
         if (req_mode == MODE_DATA) begin
            i_in           = i_next;
            perm_req.raddr = i_next;
            // The previous item still writes S[j] this cycle.
            fwd_hit_in     = (state_ff == ST_D3) && (i_next == j_ff);
            state_in       = ST_D1;
         end else begin
            if (key_room) begin
               key_req.we    = 1'b1;
               key_req.waddr = key_count_ff[KEY_AW-1:0];
               key_req.wdata = req_in_byte;
               key_count_in  = key_count_ff + KEY_CW'(1);
            end
            if (req_last) begin
               key_len_in   = key_room ? key_count_ff + KEY_CW'(1) : key_count_ff;
               key_count_in = '0;
               run_ks_in    = 1'b1;
               cnt_in       = '0;
               state_in     = ST_INIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         run_ks_ff    <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         key_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         run_ks_ff    <= run_ks_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_count_ff <= key_count_in;
      end
      si_ff      <= si_in;
      sj_ff      <= sj_in;
      k_ff       <= k_in;
      data_ff    <= data_in;
      last_ff    <= last_in;
      fwd_hit_ff <= fwd_hit_in;
      key_len_ff <= key_len_in;
      kidx_ff    <= kidx_in;
   end

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// ============================================================================
// rc4_stream_cipher
// RC4 stream cipher: loads a key, runs the key schedule and ciphers data.
// ============================================================================
//
//   Channel   Direction  Ports                              Word
//   req_      in         req_valid/req_ready                mode, in_byte, last
//   rsp_      out        rsp_valid/rsp_ready                out_byte, last_out
//
// A data word passes states D1, D2 and D3: the dependent reads of S[i], S[j] and
// S[S[i]+S[j]] share the single read port of the table memory. A key word leaves
// the block idle; the word that ends the key starts an identity sweep and
// 256 swap steps (states K0 to K3 each); no word is taken. Reset runs the sweep.
// A waiting result stalls nothing until the next data word reaches its last
// cycle; from then on no word of either mode is taken until the result leaves.
//
module rc4_stream_cipher import rc4_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_out
);

   perm_req_type      perm_req;
   key_req_type       key_req;
   res_type           res;
   logic [BYTE_W-1:0] perm_rdata;
   logic [BYTE_W-1:0] key_rdata;
   logic              out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   // The permutation table.
   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_SIZE)
   ) u_perm_ram (
      .clock (clock),
      .we    (perm_req.we),
      .waddr (perm_req.waddr),
      .wdata (perm_req.wdata),
      .raddr (perm_req.raddr),
      .rdata (perm_rdata)
   );

   // The stored key bytes.
   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (KEY_BYTES_MAX)
   ) u_key_ram (
      .clock (clock),
      .we    (key_req.we),
      .waddr (key_req.waddr),
      .wdata (key_req.wdata),
      .raddr (key_req.raddr),
      .rdata (key_rdata)
   );

   rc4_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_in_byte (req_in_byte),
      .req_last    (req_last),
      .out_free    (out_free),
      .perm_req    (perm_req),
      .perm_rdata  (perm_rdata),
      .key_req     (key_req),
      .key_rdata   (key_rdata),
      .res         (res)
   );

   // The output register is free when empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res.out_byte;
         rsp_last_in  = res.last_out;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last_out = rsp_last_ff;

`ifndef SYNTHESIS
   // A new result never overwrites a word that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (!rsp_valid_ff || rsp_ready))
      else $error("result produced while output register is occupied");

   // A data word occupies the table port, so the next cycle takes nothing.
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_DATA) |=> !req_ready)
      else $error("word accepted during data processing");

   // The last key word starts the schedule, which blocks input.
   a_key_sched: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_KEY && req_last) |=> !req_ready)
      else $error("word accepted right after key end");

   // No result appears while a data word just taken is still in D1 or D2.
   a_res_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_DATA) |=> !res.valid ##1 !res.valid)
      else $error("result produced too early");
`endif

endmodule

// ===== dv/rc4_cipher_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rc4_cipher_checker
// Watches both channels of the RC4 block, predicts each ciphered word and
// compares it field by field with what comes out.
// ============================================================================
module rc4_cipher_checker import rc4_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_mode,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              rsp_last_out,
   input  logic              drain_done,
   output int                mismatches,
   output int                outstanding,
   output int                words_checked
);

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_out;
   } cipher_word_type;

   // Words predicted but not yet seen on the result channel, oldest first.
   cipher_word_type pending_words[$];

   // Private copy of the cipher state.
   logic [BYTE_W-1:0]   sbox [TABLE_SIZE];
   logic [BYTE_W-1:0]   key_bytes [KEY_BYTES_MAX];
   logic [KEY_CW-1:0]   key_len;
   logic [TABLE_AW-1:0] pos_i;
   logic [TABLE_AW-1:0] pos_j;
   bit                  leftovers_checked;

   initial begin
      mismatches        = 0;
      outstanding       = 0;
      words_checked     = 0;
      leftovers_checked = 0;
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic swap_sbox(input logic [TABLE_AW-1:0] a, input logic [TABLE_AW-1:0] b);
      logic [BYTE_W-1:0] tmp;
      tmp     = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = tmp;
   endtask

   task automatic clear_state();
      for (int n = 0; n < TABLE_SIZE; n++)
         sbox[n] = BYTE_W'(n);
      key_len = '0;
      pos_i   = '0;
      pos_j   = '0;
      pending_words.delete();
      outstanding = 0;
   endtask

   // Key schedule over the bytes stored for the current key.
   task automatic expand_key();
      logic [BYTE_W-1:0] j;
      logic [BYTE_W-1:0] kb;
      for (int n = 0; n < TABLE_SIZE; n++)
         sbox[n] = BYTE_W'(n);
      j = '0;
      for (int n = 0; n < TABLE_SIZE; n++) begin
         kb = '0;
         if (key_len != 0)
            kb = key_bytes[n % int'(key_len)];
         j = j + kb + sbox[n];
         swap_sbox(TABLE_AW'(n), j);
      end
      pos_i = '0;
      pos_j = '0;
   endtask

   task automatic take_request(input logic mode, input logic [BYTE_W-1:0] value,
                               input logic last);
      cipher_word_type   w;
      logic [BYTE_W-1:0] k;
      if (mode == MODE_KEY) begin
         // Bytes past the key limit are dropped, but a last mark still counts.
         if (key_len < KEY_LIMIT) begin
            key_bytes[key_len[KEY_AW-1:0]] = value;
            key_len++;
         end
         if (last) begin
            expand_key();
            key_len = '0;
         end
      end else begin
         pos_i = pos_i + TABLE_AW'(1);
         pos_j = pos_j + sbox[pos_i];
         swap_sbox(pos_i, pos_j);
         k = sbox[pos_i] + sbox[pos_j];
         w.out_byte = sbox[k] ^ value;
         w.last_out = last;
         pending_words.push_back(w);
         outstanding++;
      end
   endtask

   task automatic take_result(input logic [BYTE_W-1:0] got_byte, input logic got_last);
      cipher_word_type want;
      if (pending_words.size() == 0) begin
         flag_mismatch($sformatf("result word out_byte=%h last_out=%b with none expected",
                                 got_byte, got_last));
      end else begin
         want = pending_words.pop_front();
         outstanding--;
         words_checked++;
         if (got_byte !== want.out_byte)
            flag_mismatch($sformatf("word %0d out_byte=%h, expected %h",
                                    words_checked, got_byte, want.out_byte));
         if (got_last !== want.last_out)
            flag_mismatch($sformatf("word %0d last_out=%b, expected %b",
                                    words_checked, got_last, want.last_out));
      end
   endtask

   // A result word can never stem from a request taken at the same edge, so
   // results are matched before the new request is predicted.
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_valid && rsp_ready)
            take_result(rsp_out_byte, rsp_last_out);
         if (req_valid && req_ready)
            take_request(req_mode, req_in_byte, req_last);
         if (drain_done && !leftovers_checked) begin
            leftovers_checked = 1;
            if (pending_words.size() != 0)
               flag_mismatch($sformatf("%0d expected words never arrived",
                                       pending_words.size()));
         end
      end
   end

endmodule

// ===== dv/tb_rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_rc4_stream_cipher
// Drives key loads and data buffers into the RC4 block with random idling on
// both channels; a checker beside the block predicts and compares every word.
// ============================================================================
module tb_rc4_stream_cipher;
   import rc4_pkg::*;

   // Stimulus stops once this many words that the block acts on were sent.
   localparam int ITEM_TARGET    = 550;
   // The final stretch of words runs with no idling on either side.
   localparam int QUIET_TAIL     = 100;
   // Longest legal silence is a key schedule overlapping the long receiver
   // hold-off and an idle burst; this is several times that.
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int LONG_HOLD      = 300;
   // A key word at the very end may start a schedule that runs on after the
   // last result word; wait that out before the verdict.
   localparam int SETTLE_CYCLES  = 1400;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_mode    = MODE_KEY;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              req_last    = 1'b0;
   logic              rsp_ready   = 1'b0;
   logic              drain_done  = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last_out;

   int mismatches;
   int outstanding;
   int words_checked;

   // Shared between the sender and the receiver process.
   bit idle_enable   = 1;
   int hold_requests = 0;
   int holds_served  = 0;

   // Bookkeeping for the summary and for the stop condition.
   int items_sent    = 0;
   int keys_ended    = 0;
   int longest_key   = 0;
   int dropped_bytes = 0;
   int key_fill      = 0;
   int stall_cycles  = 0;

   always #5 clock = ~clock;

   rc4_stream_cipher uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_in_byte  (req_in_byte),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last_out (rsp_last_out)
   );

   rc4_cipher_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_in_byte   (req_in_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_out  (rsp_last_out),
      .drain_done    (drain_done),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   // Offers one word and returns at the edge where it is taken. Valid stays
   // high into the next word unless an idle burst is drawn, so back-to-back
   // words never see valid dropped and raised in the same time step.
   task automatic send_word(input logic mode, input logic [BYTE_W-1:0] value,
                            input logic last);
      int gap;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_in_byte <= value;
      req_last    <= last;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      // Key bytes past the limit are ignored by the block, so they do not
      // count toward the amount of stimulus.
      if (mode == MODE_KEY) begin
         if (key_fill < KEY_BYTES_MAX) begin
            key_fill++;
            items_sent++;
         end else begin
            dropped_bytes++;
         end
         if (last) begin
            keys_ended++;
            if (key_fill + dropped_bytes > longest_key && dropped_bytes == 0)
               longest_key = key_fill;
            else if (key_fill == KEY_BYTES_MAX)
               longest_key = KEY_BYTES_MAX;
            key_fill = 0;
         end
      end else begin
         items_sent++;
      end
   endtask

   // A whole key, with the last mark on its final byte.
   task automatic send_key(input int len);
      for (int k = 0; k < len; k++)
         send_word(MODE_KEY, BYTE_W'($urandom), k == len - 1);
   endtask

   // A data buffer, with the last mark on its final byte.
   task automatic send_buffer(input int len);
      for (int k = 0; k < len; k++)
         send_word(MODE_DATA, BYTE_W'($urandom), k == len - 1);
   endtask

   // The sender goes quiet until every predicted word has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // Receiver. It idles in short random bursts, and when the sender asks for
   // a long hold-off it keeps ready low until the LONG_HOLD count kept here runs
   // out, so the block fills its output register and stalls its input.
   initial begin : receiver
      int quiet;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (quiet == 0) begin
            if (hold_requests != holds_served) begin
               holds_served++;
               quiet = LONG_HOLD;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
               quiet = $urandom_range(1, 16);
            end
         end
         if (quiet > 0) begin
            rsp_ready <= 1'b0;
            quiet--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: the run is declared hung when the count of idle clocks, with no
   // word moving on either channel, reaches WATCHDOG_LIMIT.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no word moved for %0d cycles", $time, stall_cycles);
         $display("tb_rc4_stream_cipher failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int seq;
      int choice;
      int len;
      int count;

      // Reset once; the block then clears its table before taking words.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Data before any key is ciphered with the identity table.
      send_word(MODE_DATA, 8'h00, 1'b0);
      send_word(MODE_DATA, 8'hff, 1'b0);
      send_word(MODE_DATA, 8'ha5, 1'b1);

      // Shortest key, all-zero byte, then a short buffer.
      send_word(MODE_KEY, 8'h00, 1'b1);
      send_word(MODE_DATA, 8'h00, 1'b0);
      send_word(MODE_DATA, 8'hff, 1'b1);

      // Two-byte key of all ones.
      send_word(MODE_KEY, 8'hff, 1'b0);
      send_word(MODE_KEY, 8'hff, 1'b1);
      send_buffer(3);

      // Data words slipped into a key load still use the old table, and the
      // key bytes around them must not disturb it.
      send_word(MODE_KEY, 8'h01, 1'b0);
      send_word(MODE_DATA, 8'h3c, 1'b0);
      send_word(MODE_KEY, 8'h7e, 1'b0);
      send_word(MODE_DATA, 8'hc3, 1'b1);
      send_word(MODE_KEY, 8'hfe, 1'b1);
      send_buffer(2);

      // Random part: mostly complete key loads followed by a data buffer,
      // with some keys cut by data words and some plain noise. The long
      // hold-off, the overlong key and the full drain come early enough
      // that the item target cannot be reached before them.
      seq = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_TAIL)
            idle_enable = 0;
         if (seq == 2) begin
            // Overlong key: the bytes past the limit are dropped but the last
            // mark still ends the key.
            send_key($urandom_range(KEY_BYTES_MAX + 1, KEY_BYTES_MAX + 8));
            send_buffer($urandom_range(4, 16));
         end else if (seq == 1) begin
            hold_requests++;
            send_buffer(24);
         end else if (seq == 3) begin
            wait_for_drain();
            send_buffer($urandom_range(1, 24));
         end else begin
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                 : $urandom_range(1, 16);
               send_key(len);
               send_buffer($urandom_range(1, 24));
            end else if (choice == 7) begin
               len = $urandom_range(1, 12);
               for (int k = 0; k < len; k++) begin
                  if ($urandom_range(0, 2) == 0)
                     send_word(MODE_DATA, BYTE_W'($urandom), 1'($urandom));
                  send_word(MODE_KEY, BYTE_W'($urandom), k == len - 1);
               end
            end else if (choice == 8) begin
               // Noise: any mode, any last mark, which may end a key early
               // or leave one half loaded for the next sequence.
               count = $urandom_range(1, 10);
               for (int k = 0; k < count; k++)
                  send_word(($urandom_range(0, 3) != 0) ? MODE_DATA : MODE_KEY,
                            BYTE_W'($urandom), 1'($urandom));
            end else begin
               wait_for_drain();
               send_buffer($urandom_range(1, 24));
            end
         end
         seq++;
      end

      // Let everything drain, then give a trailing schedule time to finish
      // so that a stray result word would still be caught.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      drain_done <= 1'b1;
      @(negedge clock);
      @(negedge clock);

      $display("Run covered %0d key loads (longest %0d bytes, %0d bytes past the limit)",
               keys_ended, longest_key, dropped_bytes);
      $display("and %0d checked data words over %0d sequences, %0d mismatches.",
               words_checked, seq, mismatches);
      if (mismatches == 0) begin
         $display("tb_rc4_stream_cipher passed");
      end else begin
         $display("tb_rc4_stream_cipher failed");
      end
      $finish;
   end

endmodule
